@@ hdl/tnls_pkg.sv @@
// Shared types and constants for the tensor nonzero lexicographic sort unit.
// No dependencies.
package tnls_pkg;

  localparam int unsigned NUM_IN_COORDS = 4;
  localparam int unsigned NUM_KEYS      = 4;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE_3 = 3'd4;

  localparam logic [2:0] MODE_COUNT_RST = 3'd3;
  localparam logic [2:0] MODE_COUNT_MIN = 3'd2;
  localparam logic [2:0] MODE_COUNT_MAX = 3'd4;

  typedef struct packed {
    logic [31:0] coord_0;
    logic [31:0] coord_1;
    logic [31:0] coord_2;
    logic [31:0] coord_3;
    logic [63:0] payload;
    logic        last_item;
  } in_word_t;

  typedef struct packed {
    logic [31:0] out_coord_0;
    logic [31:0] out_coord_1;
    logic [31:0] out_coord_2;
    logic [31:0] out_coord_3;
    logic [63:0] out_payload;
    logic        out_last;
    logic        dropped;
  } out_word_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                           insert;
    logic                           shift_out;
    logic [2:0]                     mode_cnt;
    logic [NUM_KEYS-1:0][1:0]       key_mode;
  } cell_cmd_t;

endpackage

@@ hdl/tnls_cell.sv @@
// One slot of the insertion chain: holds a record, compares it with the
// broadcast word and takes the new word or its neighbor's record. Uses tnls_pkg.
module tnls_cell #(
  parameter int unsigned NM = 4,
  parameter int unsigned CB = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tnls_pkg::cell_cmd_t     cmd_i,
  input  logic [NM-1:0][CB-1:0]   new_coord_i,
  input  logic [63:0]             new_payload_i,
  input  logic [NM-1:0][CB-1:0]   prev_coord_i,
  input  logic [63:0]             prev_payload_i,
  input  logic                    prev_valid_i,
  input  logic                    prev_gt_i,
  input  logic [NM-1:0][CB-1:0]   next_coord_i,
  input  logic [63:0]             next_payload_i,
  input  logic                    next_valid_i,
  output logic [NM-1:0][CB-1:0]   coord_o,
  output logic [63:0]             payload_o,
  output logic                    valid_o,
  output logic                    gt_o
);

  logic [NM-1:0][CB-1:0] coord_q, coord_d;
  logic [63:0]           payload_q, payload_d;
  logic                  valid_q, valid_d;
  logic                  new_lt;
  logic                  key_on;
  logic [CB-1:0]         key_a, key_b;

  function automatic logic [CB-1:0] pick(input logic [NM-1:0][CB-1:0] c,
                                         input logic [1:0] m);
    logic [CB-1:0] r;
    r = '0;
    for (int i = 0; i < NM; i++) begin
      if (m == 2'(i)) r = c[i];
    end
    return r;
  endfunction

  // lexicographic new < stored, last key first so the first key dominates
  always_comb begin
    new_lt = 1'b0;
    key_on = 1'b0;
    key_a  = '0;
    key_b  = '0;
    for (int k = tnls_pkg::NUM_KEYS - 1; k >= 0; k--) begin
      key_on = (3'(k) < cmd_i.mode_cnt) && ({1'b0, cmd_i.key_mode[k]} < cmd_i.mode_cnt);
      key_a  = pick(new_coord_i, cmd_i.key_mode[k]);
      key_b  = pick(coord_q, cmd_i.key_mode[k]);
      if (key_on) new_lt = (key_a < key_b) | ((key_a == key_b) & new_lt);
    end
  end

  // empty slots count as greater than anything
  assign gt_o = !valid_q || new_lt;

  always_comb begin
    coord_d   = coord_q;
    payload_d = payload_q;
    valid_d   = valid_q;
    if (cmd_i.shift_out) begin
      coord_d   = next_coord_i;
      payload_d = next_payload_i;
      valid_d   = next_valid_i;
    end else if (cmd_i.insert && gt_o) begin
      if (prev_gt_i) begin
        // shift up; an empty neighbor leaves this slot empty
        valid_d   = prev_valid_i;
        coord_d   = prev_coord_i;
        payload_d = prev_payload_i;
      end else begin
        valid_d   = 1'b1;
        coord_d   = new_coord_i;
        payload_d = new_payload_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    coord_q   <= coord_d;
    payload_q <= payload_d;
  end

  assign coord_o   = coord_q;
  assign payload_o = payload_q;
  assign valid_o   = valid_q;

endmodule

@@ hdl/tensor_nonzero_lexicographic_sort_unit.sv @@
// Throughput: one word per cycle while collecting; the word marked last starts a
// drain of the whole chain, one sorted word per cycle when the output is taken.
// After the last word is accepted the drain flag is set; each pop then registers
// the head record as the output word while the records shift along the chain.
// Input is held off during the drain. Reset empties the chain and restores the
// default mode count and key order; stored records are not cleared.
module tensor_nonzero_lexicographic_sort_unit #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned MAX_MODES  = 4,
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  tnls_pkg::in_word_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output tnls_pkg::out_word_t                  out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [tnls_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tnls_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned NMODES = (MAX_MODES < tnls_pkg::NUM_IN_COORDS) ?
                                   MAX_MODES : tnls_pkg::NUM_IN_COORDS;
  localparam logic [2:0] NMODES_3 = 3'(NMODES);

  typedef logic [NMODES-1:0][COORD_BITS-1:0] rec_coord_t;

  // configuration
  logic [2:0]                          mode_count_q;
  logic [tnls_pkg::NUM_KEYS-1:0][1:0]  key_mode_q;
  logic [2:0]                          nm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_count_q <= tnls_pkg::MODE_COUNT_RST;
      key_mode_q   <= {2'd3, 2'd2, 2'd1, 2'd0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tnls_pkg::REG_MODE_COUNT: mode_count_q  <= cfg_data_i;
        tnls_pkg::REG_KEY_MODE_0: key_mode_q[0] <= cfg_data_i[1:0];
        tnls_pkg::REG_KEY_MODE_1: key_mode_q[1] <= cfg_data_i[1:0];
        tnls_pkg::REG_KEY_MODE_2: key_mode_q[2] <= cfg_data_i[1:0];
        tnls_pkg::REG_KEY_MODE_3: key_mode_q[3] <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    nm = mode_count_q;
    if (nm < tnls_pkg::MODE_COUNT_MIN) nm = tnls_pkg::MODE_COUNT_MIN;
    if (nm > tnls_pkg::MODE_COUNT_MAX) nm = tnls_pkg::MODE_COUNT_MAX;
    if (nm > NMODES_3) nm = NMODES_3;
  end

  // control
  logic                 drain_q, drain_d;
  logic                 ovf_q, ovf_d;
  logic                 out_valid_q, out_valid_d;
  tnls_pkg::out_word_t  out_q, out_d;
  logic                 in_acc, pop, full, drain_end;
  logic [CAPACITY-1:0]  cell_valid, cell_gt;
  rec_coord_t           cell_coord [CAPACITY];
  logic [63:0]          cell_payload [CAPACITY];
  rec_coord_t           fresh;
  logic [31:0]          in_coord [tnls_pkg::NUM_IN_COORDS];
  logic [31:0]          head_coord [tnls_pkg::NUM_IN_COORDS];
  tnls_pkg::cell_cmd_t  cmd;

  assign full       = cell_valid[CAPACITY-1];
  assign in_ready_o = !drain_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign pop        = drain_q && (!out_valid_q || out_ready_i);
  assign drain_end  = pop && !cell_valid[1];

  assign in_coord[0] = in_data_i.coord_0;
  assign in_coord[1] = in_data_i.coord_1;
  assign in_coord[2] = in_data_i.coord_2;
  assign in_coord[3] = in_data_i.coord_3;

  // modes beyond the active count are stored as zero
  always_comb begin
    for (int m = 0; m < NMODES; m++) begin
      fresh[m] = (3'(m) < nm) ? COORD_BITS'(in_coord[m]) : '0;
    end
  end

  assign cmd.insert    = in_acc && !full;
  assign cmd.shift_out = pop;
  assign cmd.mode_cnt  = nm;
  assign cmd.key_mode  = key_mode_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rec_coord_t  prev_coord, next_coord;
    logic [63:0] prev_payload, next_payload;
    logic        prev_gt, prev_valid, next_valid;

    if (i == 0) begin : g_first
      assign prev_coord   = '0;
      assign prev_payload = '0;
      assign prev_valid   = 1'b0;
      assign prev_gt      = 1'b0;
    end else begin : g_mid_prev
      assign prev_coord   = cell_coord[i-1];
      assign prev_payload = cell_payload[i-1];
      assign prev_valid   = cell_valid[i-1];
      assign prev_gt      = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_coord   = '0;
      assign next_payload = '0;
      assign next_valid   = 1'b0;
    end else begin : g_mid_next
      assign next_coord   = cell_coord[i+1];
      assign next_payload = cell_payload[i+1];
      assign next_valid   = cell_valid[i+1];
    end

    tnls_cell #(
      .NM (NMODES),
      .CB (COORD_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .cmd_i          (cmd),
      .new_coord_i    (fresh),
      .new_payload_i  (in_data_i.payload),
      .prev_coord_i   (prev_coord),
      .prev_payload_i (prev_payload),
      .prev_valid_i   (prev_valid),
      .prev_gt_i      (prev_gt),
      .next_coord_i   (next_coord),
      .next_payload_i (next_payload),
      .next_valid_i   (next_valid),
      .coord_o        (cell_coord[i]),
      .payload_o      (cell_payload[i]),
      .valid_o        (cell_valid[i]),
      .gt_o           (cell_gt[i])
    );
  end

  // head of chain, masked with the current mode count
  always_comb begin
    for (int m = 0; m < tnls_pkg::NUM_IN_COORDS; m++) begin
      head_coord[m] = '0;
    end
    for (int m = 0; m < NMODES; m++) begin
      if (3'(m) < nm) head_coord[m] = 32'(cell_coord[0][m]);
    end
  end

  always_comb begin
    drain_d     = drain_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (in_acc && in_data_i.last_item) drain_d = 1'b1;
    else if (drain_end) drain_d = 1'b0;
    if (drain_end) ovf_d = 1'b0;
    else if (in_acc && full) ovf_d = 1'b1;
    if (pop) begin
      out_valid_d       = 1'b1;
      out_d.out_coord_0 = head_coord[0];
      out_d.out_coord_1 = head_coord[1];
      out_d.out_coord_2 = head_coord[2];
      out_d.out_coord_3 = head_coord[3];
      out_d.out_payload = cell_payload[0];
      out_d.out_last    = !cell_valid[1];
      out_d.dropped     = ovf_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      drain_q     <= drain_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_pop_has_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cell_valid[0])
    else $error("drain popped an empty head cell");

  a_chain_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[1] |-> cell_valid[0])
    else $error("chain has a hole at its head");

  a_last_starts_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.last_item) |=> (drain_q && cell_valid[0]))
    else $error("last word did not start a drain");

  a_last_word_ends_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_end |=> (out_valid_q && out_q.out_last && !drain_q))
    else $error("final sorted word not shown when the drain ended");

endmodule
